// ----- src/redundancy_group_failover_manager_unit_defines.svh -----
// assertion macros for the redundancy group failover manager
// used by modules that assert; relies on clk_i and rst_ni in scope
`ifndef REDUNDANCY_GROUP_FAILOVER_MANAGER_UNIT_DEFINES_SVH
`define REDUNDANCY_GROUP_FAILOVER_MANAGER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define RGFM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication checked outside reset
`define RGFM_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- src/rgfm_pkg.sv -----
// shared types, codes and constants of the redundancy group failover manager
// no dependencies
package rgfm_pkg;

  localparam int unsigned MAX_MODULES_DEF = 8;

  localparam int unsigned CFG_W      = 4;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned HEALTH_W   = 3;
  localparam int unsigned ROLE_W     = 2;
  localparam int unsigned CNT_OUT_W  = 4;
  localparam int unsigned MARGIN_W   = 5;
  localparam int unsigned CMP_W      = 5;
  localparam int unsigned CTR_W      = 16;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned M_PAD_W    = 5;

  localparam logic [CFG_W-1:0] N_RESET = 4'd2;
  localparam logic [CFG_W-1:0] M_RESET = 4'd1;
  localparam logic [CTR_W-1:0] CTR_MAX = 16'hFFFF;

  localparam logic [HEALTH_W-1:0] H_HEALTHY   = 3'd0;
  localparam logic [HEALTH_W-1:0] H_DEGRADED  = 3'd1;
  localparam logic [HEALTH_W-1:0] H_FAULTY    = 3'd2;
  localparam logic [HEALTH_W-1:0] H_OFFLINE   = 3'd3;
  localparam logic [HEALTH_W-1:0] H_FAIL_SAFE = 3'd4;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [0:0] {
    OP_ADD        = 1'b0,
    OP_SET_HEALTH = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_MODULE_TOTAL     = 1'b0,
    CFG_MODULES_REQUIRED = 1'b1
  } cfg_reg_e;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_OFFLINE   = 2'd0,
    ROLE_STANDBY   = 2'd1,
    ROLE_PRIMARY   = 2'd2,
    ROLE_SECONDARY = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic apply;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- src/rgfm_ctrl.sv -----
// controller state machine: accept, apply, slot scan, result hand-off
// depends on rgfm_pkg
module rgfm_ctrl import rgfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/rgfm_datapath.sv -----
// datapath: configuration, slot stores, scan counter and output register
// depends on rgfm_pkg and the assertion macro header
`include "redundancy_group_failover_manager_unit_defines.svh"

module rgfm_datapath import rgfm_pkg::*; #(
  parameter int unsigned MAX_MODULES = MAX_MODULES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_stat_t           stat_o,
  input  logic                 cfg_we_i,
  input  cfg_reg_e             cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  opcode_e              in_opcode_i,
  input  logic [SLOT_W-1:0]    in_slot_i,
  input  logic [HEALTH_W-1:0]  in_health_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic                 m_tuser_o
);

  localparam int unsigned IDX_W = $clog2(MAX_MODULES);
  localparam int unsigned CNT_W = $clog2(MAX_MODULES + 1);

  logic [CFG_W-1:0]    n_q, m_q, n_eff, m_eff;
  logic [HEALTH_W-1:0] health_q [MAX_MODULES];
  role_e               role_q   [MAX_MODULES];
  logic [CTR_W-1:0]    faults_q [MAX_MODULES];
  logic [SLOT_W-1:0]   primary_q;
  logic                group_ok_q, degraded_q;
  logic [CTR_W-1:0]    failovers_q;

  opcode_e             op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [HEALTH_W-1:0] health_in_q;

  logic [IDX_W-1:0]    idx_q, cand_q;
  logic [CNT_W-1:0]    count_q;
  logic                found_q;

  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic                m_tuser_q;

  logic [IDX_W-1:0]    slot_ix;
  logic                rejected, is_fault, add_op;
  role_e               add_role;
  logic [SLOT_W-1:0]   secondary;
  logic                hit_healthy;
  logic                ok_calc, deg_calc, promote;
  logic                ok_next, deg_next;
  logic [SLOT_W-1:0]   primary_next;
  logic [CTR_W-1:0]    failovers_next, faults_out;
  role_e               role_out;
  logic [MARGIN_W-1:0] margin;

  always_comb begin
    if (n_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (CMP_W'(n_q) > CMP_W'(MAX_MODULES)) begin
      n_eff = CFG_W'(MAX_MODULES);
    end else begin
      n_eff = n_q;
    end
    if (m_q == '0) begin
      m_eff = CFG_W'(1);
    end else if (m_q > n_eff) begin
      m_eff = n_eff;
    end else begin
      m_eff = m_q;
    end
  end

  assign secondary = (n_eff > CFG_W'(1)) ? SLOT_W'(1) : '0;
  assign slot_ix   = IDX_W'(slot_q);
  assign rejected  = CMP_W'(slot_q) >= CMP_W'(n_eff);
  assign add_op    = (op_q == OP_ADD);
  assign is_fault  = (health_in_q == H_FAULTY) || (health_in_q == H_OFFLINE);

  always_comb begin
    if (slot_q == '0) begin
      add_role = ROLE_PRIMARY;
    end else if (slot_q == SLOT_W'(1) && n_eff > CFG_W'(1)) begin
      add_role = ROLE_SECONDARY;
    end else begin
      add_role = ROLE_STANDBY;
    end
  end

  assign hit_healthy = (CMP_W'(idx_q) < CMP_W'(n_eff)) && (health_q[idx_q] == H_HEALTHY);

  assign stat_o.scan_last = (idx_q == IDX_W'(MAX_MODULES - 1));
  assign stat_o.out_free  = !m_valid_q || m_ready_i;

  // end-of-event evaluation
  always_comb begin
    ok_calc  = CMP_W'(count_q) >= CMP_W'(m_eff);
    deg_calc = (CMP_W'(count_q) < CMP_W'(n_eff)) && ok_calc;
    promote  = !rejected && !add_op && (slot_q == primary_q) &&
               (health_in_q != H_HEALTHY) && found_q;
    ok_next  = rejected ? group_ok_q : ok_calc;
    deg_next = (rejected || add_op) ? degraded_q : deg_calc;
    primary_next   = promote ? SLOT_W'(cand_q) : primary_q;
    failovers_next = (promote && failovers_q != CTR_MAX) ? failovers_q + CTR_W'(1)
                                                          : failovers_q;
    faults_out = rejected ? '0 : faults_q[slot_ix];
    role_out   = rejected ? ROLE_OFFLINE : role_q[slot_ix];
    margin     = MARGIN_W'(CMP_W'(count_q) - CMP_W'(m_eff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_RESET;
      m_q <= M_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODULE_TOTAL:     n_q <= cfg_data_i;
        CFG_MODULES_REQUIRED: m_q <= cfg_data_i;
        default:              n_q <= n_q;
      endcase
    end
  end

  // group state, cleared by reset and by any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MODULES; i++) begin
        health_q[i] <= H_OFFLINE;
        role_q[i]   <= ROLE_OFFLINE;
        faults_q[i] <= '0;
      end
      primary_q   <= '0;
      group_ok_q  <= 1'b0;
      degraded_q  <= 1'b0;
      failovers_q <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_MODULES; i++) begin
        health_q[i] <= H_OFFLINE;
        role_q[i]   <= ROLE_OFFLINE;
        faults_q[i] <= '0;
      end
      primary_q   <= '0;
      group_ok_q  <= 1'b0;
      degraded_q  <= 1'b0;
      failovers_q <= '0;
    end else begin
      if (cmd_i.apply && !rejected) begin
        if (add_op) begin
          health_q[slot_ix] <= H_HEALTHY;
          faults_q[slot_ix] <= '0;
          role_q[slot_ix]   <= add_role;
          if (slot_q == '0) primary_q <= '0;
        end else begin
          health_q[slot_ix] <= health_in_q;
          if (is_fault) begin
            if (faults_q[slot_ix] != CTR_MAX) faults_q[slot_ix] <= faults_q[slot_ix] + CTR_W'(1);
            if (slot_q == primary_q && role_q[slot_ix] == ROLE_PRIMARY) begin
              role_q[slot_ix] <= ROLE_OFFLINE;
            end
          end
        end
      end
      if (cmd_i.finish) begin
        group_ok_q  <= ok_next;
        degraded_q  <= deg_next;
        primary_q   <= primary_next;
        failovers_q <= failovers_next;
        if (promote) role_q[cand_q] <= ROLE_PRIMARY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= in_opcode_i;
      slot_q      <= in_slot_i;
      health_in_q <= in_health_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
      found_q <= 1'b0;
      cand_q  <= '0;
    end else if (cmd_i.apply) begin
      idx_q   <= '0;
      count_q <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (hit_healthy) begin
        count_q <= count_q + CNT_W'(1);
        if (!found_q && idx_q != slot_ix) begin
          found_q <= 1'b1;
          cand_q  <= idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_tuser_q <= rejected ? STATUS_REJECTED : STATUS_DONE;
      m_tdata_q <= {M_PAD_W'(0), role_out, faults_out, failovers_next, margin, secondary,
                    primary_next, deg_next, ok_next, CNT_OUT_W'(count_q)};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_tdata_o = m_tdata_q;
  assign m_tuser_o = m_tuser_q;

  `RGFM_ASSERT(a_finish_sets_valid, cmd_i.finish |=> m_valid_q, "result register not loaded")
  `RGFM_ASSERT_IMPL(a_count_bounded, cmd_i.step, CMP_W'(count_q) <= CMP_W'(idx_q),
                    "healthy count ahead of scan index")
  `RGFM_ASSERT(a_failovers_monotonic, !cfg_we_i |=> failovers_q >= $past(failovers_q),
               "failover count decreased without clear")

endmodule

// ----- src/redundancy_group_failover_manager_unit.sv -----
// top level of the M-out-of-N redundancy group failover manager
// depends on rgfm_pkg, rgfm_ctrl and rgfm_datapath
//
// input stream: one event per transaction, tuser = opcode (add / set health),
// tdata = slot [2:0], health [5:3]. output stream: one result per event,
// tuser = status (done / rejected), tdata = healthy_count [3:0], group_ok [4],
// degraded [5], primary_slot [8:6], secondary_slot [11:9], spare_margin [16:12],
// failovers [32:17], slot_faults [48:33], slot_role [50:49].
// config channel: cfg_index_i 0 writes N, 1 writes M; either write clears the
// whole group; cfg_ready_o is always high, and writes only when idle is a rule
// for the user that the block itself does not enforce. one event at a time:
// accept, an apply state, a scan over MAX_MODULES slots (one slot a cycle,
// counting healthy slots and finding the promotion candidate), then a finish
// state loading the result register.
// reset: N = 2, M = 1, all slots offline, counters zero, no result pending.
// a stalled receiver holds the result register; the next event is accepted
// but its result waits until the pending transaction completes.
module redundancy_group_failover_manager_unit import rgfm_pkg::*; #(
  parameter int unsigned MAX_MODULES = MAX_MODULES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // slot, health, zero pad
  input  logic                 s_axis_tuser,   // opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // healthy_count, group_ok, degraded,
                                               // primary_slot, secondary_slot,
                                               // spare_margin, failovers,
                                               // slot_faults, slot_role, zero pad
  output logic                 m_axis_tuser,   // status
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rgfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rgfm_datapath #(
    .MAX_MODULES (MAX_MODULES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .in_opcode_i (opcode_e'(s_axis_tuser)),
    .in_slot_i   (s_axis_tdata[SLOT_W-1:0]),
    .in_health_i (s_axis_tdata[SLOT_W+HEALTH_W-1:SLOT_W]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
